FILE: rtl/rdsna_pkg.sv
// Package with the shared types and constants of the RDS station name assembler.
`timescale 1ns / 1ps
`default_nettype none

package rdsna_pkg;

    localparam int NAME_CHARS = 8;
    localparam int CHAR_W     = 8;
    localparam int WORD_W     = 16;
    localparam int SEG_W      = 2;
    localparam int GROUP_W    = 5;
    localparam int NAME_W     = NAME_CHARS * CHAR_W;

    localparam logic FUNC_PROCESS = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    localparam int RDS_READY_BIT = 15;
    localparam int GROUP_LSB     = 11;

    localparam logic [GROUP_W-1:0] GROUP_0A = 5'b00000;
    localparam logic [GROUP_W-1:0] GROUP_0B = 5'b00001;

    localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'h7D;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [NAME_W-1:0] name_t;

    typedef struct packed {
        logic clr;
        logic take;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/rdsna_if.sv
// Channel interfaces for the update items and the name results.
`timescale 1ns / 1ps
`default_nettype none

interface rdsna_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] status_word;
    logic [15:0] block_b;
    logic [15:0] block_d;

    modport source (output valid, output func, output status_word, output block_b,
                    output block_d, input ready);
    modport sink (input valid, input func, input status_word, input block_b,
                  input block_d, output ready);
endinterface

interface rdsna_result_if;
    logic        valid;
    logic        ready;
    logic        has_station_info;
    logic [63:0] station_name;

    modport source (output valid, output has_station_info, output station_name,
                    input ready);
    modport sink (input valid, input has_station_info, input station_name,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/rdsna_char_cell.sv
// One character position: candidate and confirmed character registers with their update rule.
`timescale 1ns / 1ps
`default_nettype none

module rdsna_char_cell
    import rdsna_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire char_t      ch,
    output char_t           conf,
    output char_t           conf_next
);

    char_t cand_reg;
    char_t cand_next;
    char_t conf_reg;
    logic  printable;

    assign printable = (ch >= PRINT_LOW) && (ch <= PRINT_HIGH);

    always_comb
    begin
        cand_next = cand_reg;
        conf_next = conf_reg;
        if (ctrl.clr)
        begin
            cand_next = '0;
            conf_next = '0;
        end
        else if (ctrl.take)
        begin
            if (cand_reg == ch)
            begin
                conf_next = ch;
            end
            else if (printable)
            begin
                cand_next = ch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
            conf_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            conf_reg <= conf_next;
        end
    end

    assign conf = conf_reg;

endmodule

`default_nettype wire

FILE: rtl/rds_station_name_assembler_unit.sv
// Top level of the RDS station name assembler.
//
// The item channel takes one transaction per RDS group: func selects a
// normal update or a clear of both character stores, and the status word,
// block B and block D carry the received data. An update counts only when
// status bit 15 is set and the group is type 0A or 0B; block B bits 1:0
// then pick a character pair and block D supplies the two characters.
// The result channel gives exactly one transaction per item: the flag that
// the group carried station information, and the confirmed eight-character
// name after the item, character 0 in the low byte.
// An item is taken into an input register, evaluated by combinational logic
// and written to the result register, which drives the result channel; one
// item per cycle is sustained while the receiver takes each result.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; the item channel stalls after that.
// Reset clears both stores to zero and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module rds_station_name_assembler_unit
    import rdsna_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rdsna_item_if.sink      item,
    rdsna_result_if.source  result
);

    logic                in_valid_reg;
    logic                func_reg;
    logic [WORD_W-1:0]   status_reg;
    logic [WORD_W-1:0]   block_b_reg;
    logic [WORD_W-1:0]   block_d_reg;

    logic                out_valid_reg;
    logic                has_info_reg;
    name_t               name_reg;

    logic                advance;
    logic                accept;
    logic                hit;
    logic [GROUP_W-1:0]  group;
    logic [SEG_W-1:0]    seg;
    name_t               name_cur;
    name_t               name_new;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign accept = item.valid && item.ready;

    assign group = block_b_reg[GROUP_LSB +: GROUP_W];
    assign seg   = block_b_reg[SEG_W-1:0];
    assign hit   = (func_reg == FUNC_PROCESS) && status_reg[RDS_READY_BIT]
                   && ((group == GROUP_0A) || (group == GROUP_0B));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= item.func;
            status_reg  <= item.status_word;
            block_b_reg <= item.block_b;
            block_d_reg <= item.block_d;
        end
    end

    for (genvar i = 0; i < NAME_CHARS; i++)
    begin : g_cell
        localparam logic [SEG_W-1:0] PAIR = SEG_W'(i / 2);
        cell_ctrl_t ctrl;
        char_t      ch;
        char_t      conf;
        char_t      conf_next;

        assign ctrl.clr  = advance && (func_reg == FUNC_CLEAR);
        assign ctrl.take = advance && hit && (seg == PAIR);
        assign ch = ((i % 2) == 0) ? block_d_reg[2*CHAR_W-1:CHAR_W] : block_d_reg[CHAR_W-1:0];

        rdsna_char_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .ch        (ch),
            .conf      (conf),
            .conf_next (conf_next)
        );

        assign name_cur[i*CHAR_W +: CHAR_W] = conf;
        assign name_new[i*CHAR_W +: CHAR_W] = conf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            has_info_reg <= hit;
            name_reg     <= name_new;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.has_station_info = has_info_reg;
    assign result.station_name     = name_reg;

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (func_reg == FUNC_CLEAR)) |=>
        (out_valid_reg && !has_info_reg && (name_reg == '0)))
        else $error("A clear transaction did not give an empty name.");

    a_idle_name_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !hit && (func_reg == FUNC_PROCESS)) |=>
        (name_reg == $past(name_cur)))
        else $error("An ignored group changed the confirmed name.");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> item.ready)
        else $error("The empty input register refused a transaction.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && (name_reg == name_cur)))
        else $error("The result does not match the stored name.");

endmodule

`default_nettype wire
